### design/ftsm_pkg.sv
// Shared types and constants for the frame timestamp sequence matcher.
// No dependencies; the cell, row and top-level design files import this package.
`default_nettype none

package ftsm_pkg;

  localparam int SEQ_W  = 32;
  localparam int TAG_W  = 16;
  localparam int TIME_W = 63;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_STAMP = 1'b1;

  // Per-row control broadcast to every cell of a row.
  typedef struct packed {
    logic cmp_en;  // latch sequence compare against key
    logic take;    // remove the newest matching entry
    logic push;    // append key/new data, dropping the oldest when full
  } row_ctl_t;

endpackage

`default_nettype wire

### design/ftsm_cell.sv
// One buffer cell: a valid entry of sequence number plus data word.
// Shifts from its upper neighbor on removal and on append to a full row; otherwise loads new items on append.
// Depends on ftsm_pkg.
`default_nettype none

module ftsm_cell #(
  parameter int DW = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ftsm_pkg::row_ctl_t         ctl,
  input  logic [ftsm_pkg::SEQ_W-1:0] key,
  input  logic [DW-1:0]              new_data,
  input  logic                       valid_below_i,
  input  logic                       hit_above_i,
  input  logic                       shift_below_i,
  input  logic                       up_valid_i,
  input  logic [ftsm_pkg::SEQ_W-1:0] up_seq_i,
  input  logic [DW-1:0]              up_data_i,
  output logic                       valid_o,
  output logic [ftsm_pkg::SEQ_W-1:0] seq_o,
  output logic [DW-1:0]              data_o,
  output logic                       hit_above_o,
  output logic                       shift_o,
  output logic [DW-1:0]              sel_data_o
);
  import ftsm_pkg::*;

  logic             valid_r, valid_nxt;
  logic             hit_r, hit_nxt;
  logic [SEQ_W-1:0] seq_r, seq_nxt;
  logic [DW-1:0]    data_r, data_nxt;
  logic             sel;
  logic             load_new;

  assign sel         = hit_r & ~hit_above_i;
  assign hit_above_o = hit_above_i | hit_r;
  assign shift_o     = shift_below_i | (ctl.take & sel);
  assign load_new    = ctl.push & ~valid_r & valid_below_i;
  assign sel_data_o  = sel ? data_r : '0;
  assign valid_o     = valid_r;
  assign seq_o       = seq_r;
  assign data_o      = data_r;

  always_comb begin
    valid_nxt = valid_r;
    seq_nxt   = seq_r;
    data_nxt  = data_r;
    hit_nxt   = hit_r;
    if (ctl.cmp_en) begin
      hit_nxt = valid_r & (seq_r == key);
    end
    if (shift_o) begin
      valid_nxt = up_valid_i;
      seq_nxt   = up_seq_i;
      data_nxt  = up_data_i;
    end else if (load_new) begin
      valid_nxt = 1'b1;
      seq_nxt   = key;
      data_nxt  = new_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      hit_r   <= hit_nxt;
    end
    seq_r  <= seq_nxt;
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

### design/ftsm_row.sv
// One ordered buffer built as a chain of ftsm_cell, oldest entry at cell 0.
// Gives the any-match flag and the data of the newest matching entry.
// Depends on ftsm_pkg and ftsm_cell.
`default_nettype none

module ftsm_row #(
  parameter int DEPTH = 8,
  parameter int DW    = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ftsm_pkg::row_ctl_t         ctl,
  input  logic [ftsm_pkg::SEQ_W-1:0] key,
  input  logic [DW-1:0]              new_data,
  output logic                       any_hit,
  output logic [DW-1:0]              hit_data
);
  import ftsm_pkg::*;

  logic [DEPTH-1:0] valid_w;
  logic [DEPTH-1:0] hit_above_w;
  logic [DEPTH-1:0] shift_w;
  logic [DEPTH-1:0] up_valid_w;
  logic [DEPTH-1:0] valid_below_w;
  logic [DEPTH-1:0] hit_in_w;
  logic [DEPTH-1:0] shift_in_w;
  logic [SEQ_W-1:0] seq_w     [DEPTH];
  logic [SEQ_W-1:0] up_seq_w  [DEPTH];
  logic [DW-1:0]    data_w    [DEPTH];
  logic [DW-1:0]    up_data_w [DEPTH];
  logic [DW-1:0]    sel_w     [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_top
      assign up_valid_w[i] = ctl.push;
      assign up_seq_w[i]   = key;
      assign up_data_w[i]  = new_data;
      assign hit_in_w[i]   = 1'b0;
    end else begin : g_mid
      assign up_valid_w[i] = valid_w[i+1];
      assign up_seq_w[i]   = seq_w[i+1];
      assign up_data_w[i]  = data_w[i+1];
      assign hit_in_w[i]   = hit_above_w[i+1];
    end
    if (i == 0) begin : g_bot
      assign valid_below_w[i] = 1'b1;
      assign shift_in_w[i]    = ctl.push & valid_w[DEPTH-1];
    end else begin : g_upper
      assign valid_below_w[i] = valid_w[i-1];
      assign shift_in_w[i]    = shift_w[i-1];
    end

    ftsm_cell #(.DW(DW)) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .key          (key),
      .new_data     (new_data),
      .valid_below_i(valid_below_w[i]),
      .hit_above_i  (hit_in_w[i]),
      .shift_below_i(shift_in_w[i]),
      .up_valid_i   (up_valid_w[i]),
      .up_seq_i     (up_seq_w[i]),
      .up_data_i    (up_data_w[i]),
      .valid_o      (valid_w[i]),
      .seq_o        (seq_w[i]),
      .data_o       (data_w[i]),
      .hit_above_o  (hit_above_w[i]),
      .shift_o      (shift_w[i]),
      .sel_data_o   (sel_w[i])
    );
  end

  assign any_hit = hit_above_w[0];

  always_comb begin
    hit_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_data = hit_data | sel_w[i];
    end
  end

endmodule

`default_nettype wire

### design/frame_timestamp_sequence_matcher_unit.sv
// Frame timestamp sequence matcher, top level. For each item, busy is high
// for the cycle after start is taken. When start is taken, the sequence
// number is compared against every cell of both buffers at once; in the
// update state the item removes the newest match from the other buffer
// or is appended to its own buffer. A match gives one result on out_valid
// in the cycle after that; the receiver cannot stall, and a new item may
// be started while it shows. Depends on ftsm_pkg and ftsm_row.
`default_nettype none

module frame_timestamp_sequence_matcher_unit #(
  parameter int DEPTH = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_cmd,
  input  logic [ftsm_pkg::SEQ_W-1:0]  in_seq,
  input  logic [ftsm_pkg::TAG_W-1:0]  in_frame_tag,
  input  logic [ftsm_pkg::TIME_W-1:0] in_stamp_time,
  output logic                        out_valid,
  output logic [ftsm_pkg::TAG_W-1:0]  out_tag,
  output logic [ftsm_pkg::SEQ_W-1:0]  out_seq,
  output logic [ftsm_pkg::TIME_W-1:0] out_time
);
  import ftsm_pkg::*;

  typedef enum logic {ST_IDLE, ST_UPDATE} state_t;

  state_t            state_r;
  logic              cmd_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [TAG_W-1:0]  tag_r;
  logic [TIME_W-1:0] time_r;
  logic              out_valid_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic [SEQ_W-1:0]  out_seq_r;
  logic [TIME_W-1:0] out_time_r;

  logic              accept;
  logic              updating;
  logic [SEQ_W-1:0]  key;
  logic              frame_hit, stamp_hit;
  logic [TAG_W-1:0]  frame_data;
  logic [TIME_W-1:0] stamp_data;
  logic              opp_hit;
  row_ctl_t          frame_ctl, stamp_ctl;

  assign accept   = start & (state_r == ST_IDLE);
  assign updating = (state_r == ST_UPDATE);
  assign key      = updating ? seq_r : in_seq;
  assign opp_hit  = (cmd_r == CMD_FRAME) ? stamp_hit : frame_hit;

  always_comb begin
    frame_ctl.cmp_en = accept;
    frame_ctl.take   = updating & (cmd_r == CMD_STAMP) & frame_hit;
    frame_ctl.push   = updating & (cmd_r == CMD_FRAME) & ~stamp_hit;
    stamp_ctl.cmp_en = accept;
    stamp_ctl.take   = updating & (cmd_r == CMD_FRAME) & stamp_hit;
    stamp_ctl.push   = updating & (cmd_r == CMD_STAMP) & ~frame_hit;
  end

  ftsm_row #(.DEPTH(DEPTH), .DW(TAG_W)) u_frame_row (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (frame_ctl),
    .key     (key),
    .new_data(tag_r),
    .any_hit (frame_hit),
    .hit_data(frame_data)
  );

  ftsm_row #(.DEPTH(DEPTH), .DW(TIME_W)) u_stamp_row (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (stamp_ctl),
    .key     (key),
    .new_data(time_r),
    .any_hit (stamp_hit),
    .hit_data(stamp_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          state_r     <= ST_IDLE;
          out_valid_r <= opp_hit;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
    if (accept) begin
      cmd_r  <= in_cmd;
      seq_r  <= in_seq;
      tag_r  <= in_frame_tag;
      time_r <= in_stamp_time;
    end
    if (updating) begin
      out_seq_r  <= seq_r;
      out_tag_r  <= (cmd_r == CMD_FRAME) ? tag_r : frame_data;
      out_time_r <= (cmd_r == CMD_FRAME) ? stamp_data : time_r;
    end
  end

  assign busy      = updating;
  assign out_valid = out_valid_r;
  assign out_tag   = out_tag_r;
  assign out_seq   = out_seq_r;
  assign out_time  = out_time_r;

endmodule

`default_nettype wire

### design/ftsm_checker.sv
// Port-level checker for the frame timestamp sequence matcher, bound to
// the top level. Depends on frame_timestamp_sequence_matcher_unit.
`default_nettype none

module ftsm_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted item");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without an item in update");

  a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

endmodule

bind frame_timestamp_sequence_matcher_unit ftsm_checker u_ftsm_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid)
);

`default_nettype wire

### tb/tb_frame_timestamp_sequence_matcher_unit.sv
`timescale 1ns / 1ps
// Testbench for frame_timestamp_sequence_matcher_unit: directed and random frames
// and trigger stamps, with results checked against an in-bench model of both buffers.
// Depends on ftsm_pkg and the matcher RTL.

module tb_frame_timestamp_sequence_matcher_unit;
  import ftsm_pkg::*;

  localparam int DEPTH      = 8;
  localparam int RAND_ITEMS = 1000;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic              cmd;
    logic [SEQ_W-1:0]  seq;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] stime;
  } sync_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] stime;
  } frame_pair_t;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              start         = 1'b0;
  logic              in_cmd        = CMD_FRAME;
  logic [SEQ_W-1:0]  in_seq        = '0;
  logic [TAG_W-1:0]  in_frame_tag  = '0;
  logic [TIME_W-1:0] in_stamp_time = '0;
  logic              busy;
  logic              out_valid;
  logic [TAG_W-1:0]  out_tag;
  logic [SEQ_W-1:0]  out_seq;
  logic [TIME_W-1:0] out_time;

  sync_item_t  send_q[$];
  frame_pair_t pair_q[$];
  int          n_sent;
  int          n_taken;
  int          err_cnt;
  int          idle_cyc;

  logic [SEQ_W-1:0]  frm_seq  [DEPTH];
  logic [TAG_W-1:0]  frm_tag  [DEPTH];
  int                frm_cnt;
  logic [SEQ_W-1:0]  stp_seq  [DEPTH];
  logic [TIME_W-1:0] stp_time [DEPTH];
  int                stp_cnt;

  sync_item_t cur;
  int         gap;
  logic       holding;
  logic       burst;

  frame_timestamp_sequence_matcher_unit #(.DEPTH(DEPTH)) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_seq       (in_seq),
    .in_frame_tag (in_frame_tag),
    .in_stamp_time(in_stamp_time),
    .out_valid    (out_valid),
    .out_tag      (out_tag),
    .out_seq      (out_seq),
    .out_time     (out_time)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic pair_item(input sync_item_t it);
    int          hit;
    int          i;
    frame_pair_t pr;
    hit = -1;
    if (it.cmd == CMD_FRAME) begin
      for (i = stp_cnt - 1; i >= 0 && hit < 0; i--)
        if (stp_seq[i] == it.seq) hit = i;
      if (hit >= 0) begin
        pr.tag   = it.tag;
        pr.seq   = it.seq;
        pr.stime = stp_time[hit];
        pair_q   = {pair_q, pr};
        for (i = hit; i < stp_cnt - 1; i++) begin
          stp_seq[i]  = stp_seq[i + 1];
          stp_time[i] = stp_time[i + 1];
        end
        stp_cnt--;
      end else begin
        if (frm_cnt == DEPTH) begin
          for (i = 0; i < DEPTH - 1; i++) begin
            frm_seq[i] = frm_seq[i + 1];
            frm_tag[i] = frm_tag[i + 1];
          end
          frm_cnt--;
        end
        frm_seq[frm_cnt] = it.seq;
        frm_tag[frm_cnt] = it.tag;
        frm_cnt++;
      end
    end else begin
      for (i = frm_cnt - 1; i >= 0 && hit < 0; i--)
        if (frm_seq[i] == it.seq) hit = i;
      if (hit >= 0) begin
        pr.tag   = frm_tag[hit];
        pr.seq   = it.seq;
        pr.stime = it.stime;
        pair_q   = {pair_q, pr};
        for (i = hit; i < frm_cnt - 1; i++) begin
          frm_seq[i] = frm_seq[i + 1];
          frm_tag[i] = frm_tag[i + 1];
        end
        frm_cnt--;
      end else begin
        if (stp_cnt == DEPTH) begin
          for (i = 0; i < DEPTH - 1; i++) begin
            stp_seq[i]  = stp_seq[i + 1];
            stp_time[i] = stp_time[i + 1];
          end
          stp_cnt--;
        end
        stp_seq[stp_cnt]  = it.seq;
        stp_time[stp_cnt] = it.stime;
        stp_cnt++;
      end
    end
  endtask

  // Driver: present the next item, hold it until taken, then idle a drawn gap.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        pair_item(cur);
        n_taken++;
        gap     = burst ? 0 : $urandom_range(0, 6);
        holding = 1'b0;
      end
      if (!holding) begin
        if (gap > 0) begin
          gap--;
        end else if (send_q.size() != 0) begin
          cur           = send_q.pop_front();
          holding       = 1'b1;
          in_cmd        <= cur.cmd;
          in_seq        <= cur.seq;
          in_frame_tag  <= cur.tag;
          in_stamp_time <= cur.stime;
        end
      end
      start <= holding;
    end
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    frame_pair_t want;
    if (rst_n && out_valid) begin
      if (pair_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got tag %h seq %h time %h",
                 $time, out_tag, out_seq, out_time);
        err_cnt++;
      end else begin
        want = pair_q.pop_front();
        check_field("out_tag", 64'(want.tag), 64'(out_tag));
        check_field("out_seq", 64'(want.seq), 64'(out_seq));
        check_field("out_time", 64'(want.stime), 64'(out_time));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= IDLE_LIMIT) begin
      $display("tb_frame_timestamp_sequence_matcher_unit NOT OK");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  task automatic post(input logic cmd, input logic [SEQ_W-1:0] seq,
                      input logic [TAG_W-1:0] tag, input logic [TIME_W-1:0] stime);
    sync_item_t it;
    it.cmd   = cmd;
    it.seq   = seq;
    it.tag   = tag;
    it.stime = stime;
    send_q   = {send_q, it};
    n_sent++;
  endtask

  // Hold the sender until every item is taken and every result has come.
  task automatic hold_until_empty();
    while (n_taken != n_sent) @(posedge clk);
    while (pair_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int               k;
    int               i;
    int               frame_pct;
    logic [SEQ_W-1:0] seq_base;
    logic             cmd;
    logic [SEQ_W-1:0] seq;
    logic [TIME_W-1:0] stime;

    holding = 1'b0;
    burst   = 1'b0;
    gap     = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    post(CMD_FRAME, '0, '0, '1);
    post(CMD_STAMP, '0, '1, '0);
    post(CMD_STAMP, '1, '0, '1);
    post(CMD_FRAME, '1, '1, '0);
    post(CMD_FRAME, 32'd5, 16'd1, '0);
    post(CMD_FRAME, 32'd5, 16'd2, '0);
    post(CMD_FRAME, 32'd5, 16'd3, '0);
    post(CMD_STAMP, 32'd5, '0, 63'h123);
    post(CMD_STAMP, 32'd5, '0, 63'h456);
    for (i = 0; i < DEPTH + 1; i++)
      post(CMD_STAMP, 32'd100 + i, '0, 63'h1000 + i);
    post(CMD_FRAME, 32'd100, 16'h000a, '0);
    post(CMD_FRAME, 32'd108, 16'h000b, '0);
    post(CMD_FRAME, 32'd101, 16'h000c, '0);
    post(CMD_STAMP, 32'd5, '0, 63'h789);
    hold_until_empty();

    frame_pct = 50;
    seq_base  = $urandom;
    for (k = 0; k < RAND_ITEMS; k++) begin
      if (k % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       frame_pct = 20;
          1:       frame_pct = 50;
          default: frame_pct = 80;
        endcase
        burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 1) == 1) seq_base = $urandom;
      end
      if (k % 250 == 249) hold_until_empty();
      cmd = ($urandom_range(0, 99) < frame_pct) ? CMD_FRAME : CMD_STAMP;
      if ($urandom_range(0, 9) < 8) seq = seq_base + $urandom_range(0, 11);
      else seq = $urandom;
      stime = TIME_W'({$urandom, $urandom});
      case ($urandom_range(0, 19))
        0:       stime = '1;
        1:       stime = '0;
        default: ;
      endcase
      post(cmd, seq, TAG_W'($urandom), stime);
      if ($urandom_range(0, 7) == 0) seq_base = seq_base + 4;
    end

    hold_until_empty();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_frame_timestamp_sequence_matcher_unit OK");
    end else begin
      $display("tb_frame_timestamp_sequence_matcher_unit NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
design/ftsm_pkg.sv
design/ftsm_cell.sv
design/ftsm_row.sv
design/frame_timestamp_sequence_matcher_unit.sv
design/ftsm_checker.sv
tb/tb_frame_timestamp_sequence_matcher_unit.sv
